[rtl/aora_pkg.sv]
// Shared types and constants for the action/option range ACL block.
// No dependencies; imported by aora_regs, aora_ctrl and the top module of the block.
package aora_pkg;

	localparam int ACTION_W  = 16;
	localparam int BOUND_W   = 16;
	localparam int COUNT_W   = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// rule entry: {any, action}; range entry: {valid, high, low}
	localparam int RULE_ENTRY_W  = ACTION_W + 1;
	localparam int RANGE_ENTRY_W = 2 * BOUND_W + 1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic [0:0] REG_ALLOW_ALL  = 1'b0;
	localparam logic [0:0] REG_RULE_COUNT = 1'b1;

	typedef struct packed {
		logic               allow_all;
		logic [COUNT_W-1:0] rule_count;
	} cfg_t;

endpackage

[rtl/aora_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module aora_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/aora_regs.sv]
// APB-style configuration registers: allow-all flag and rule count.
// Depends on aora_pkg.
module aora_regs import aora_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [0:0] reg_idx;

	assign reg_idx = paddr[2:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_ALLOW_ALL:  cfg_q.allow_all  <= pwdata[0];
				REG_RULE_COUNT: cfg_q.rule_count <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ALLOW_ALL:  prdata = {{(PDATA_W-1){1'b0}}, cfg_q.allow_all};
			REG_RULE_COUNT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, cfg_q.rule_count};
			default:        prdata = '0;
		endcase
	end

endmodule

[rtl/aora_ctrl.sv]
// Sequencer: clearing pass, rule loads and the slot-by-slot check scan over
// the rule and range memories. Depends on aora_pkg.
module aora_ctrl import aora_pkg::*; #(
	parameter int MAX_RULES  = 16,
	parameter int MAX_RANGES = 8,
	parameter int RULE_AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
	parameter int SLOT_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
	parameter int RANGE_AW   = RULE_AW + SLOT_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     start,
	output logic                     busy,
	input  logic                     operation,
	input  logic [3:0]               rule_index,
	input  logic [2:0]               slot_index,
	input  logic [ACTION_W-1:0]      rule_action_id,
	input  logic                     rule_any_action,
	input  logic [BOUND_W-1:0]       slot_low,
	input  logic [BOUND_W-1:0]       slot_high,
	input  logic                     slot_enable,
	input  logic [ACTION_W-1:0]      query_action,
	input  logic [BOUND_W-1:0]       query_option,
	output logic                     done,
	output logic                     authorized,
	output logic                     no_rules,
	output logic                     load_rejected,
	output logic                     rule_we,
	output logic [RULE_AW-1:0]       rule_waddr,
	output logic [RULE_ENTRY_W-1:0]  rule_wdata,
	output logic [RULE_AW-1:0]       rule_raddr,
	input  logic [RULE_ENTRY_W-1:0]  rule_rdata,
	output logic                     range_we,
	output logic [RANGE_AW-1:0]      range_waddr,
	output logic [RANGE_ENTRY_W-1:0] range_wdata,
	output logic [RANGE_AW-1:0]      range_raddr,
	input  logic [RANGE_ENTRY_W-1:0] range_rdata
);

	localparam int RANGE_DEPTH = MAX_RULES * (1 << SLOT_W);
	localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(MAX_RANGES - 1);
	localparam logic [RANGE_AW-1:0] CLR_LAST  = RANGE_AW'(RANGE_DEPTH - 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN} state_t;

	state_t                state_q;
	logic [RANGE_AW-1:0]   clr_q;
	logic [RULE_AW-1:0]    rule_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [RULE_AW-1:0]    last_rule_q;
	logic                  issuing_q;
	logic                  rd_valid_s1;
	logic                  rd_last_s1;
	logic [ACTION_W-1:0]   qact_q;
	logic [BOUND_W-1:0]    qopt_q;
	logic                  done_q;
	logic                  auth_q;
	logic                  none_q;
	logic                  rej_q;

	logic                  accept;
	logic                  bad_bounds;
	logic                  in_range;
	logic                  issue_last;
	logic                  hit;
	logic [8:0]            n_rules;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign bad_bounds = slot_low > slot_high;
	assign in_range   = ({5'd0, rule_index} < 9'(MAX_RULES))
		&& ({4'd0, slot_index} < 7'(MAX_RANGES));
	// clamp to table size; only used when the count is non-zero
	assign n_rules    = ({4'd0, cfg.rule_count} > 9'(MAX_RULES)) ?
		9'(MAX_RULES) : {4'd0, cfg.rule_count};
	assign issue_last = (rule_q == last_rule_q) && (slot_q == SLOT_LAST);

	// load writes go straight into the memories at the accepting edge
	assign rule_we     = accept && (operation == OP_LOAD) && !bad_bounds && in_range;
	assign rule_waddr  = RULE_AW'(rule_index);
	assign rule_wdata  = {rule_any_action, rule_action_id};
	assign rule_raddr  = rule_q;

	assign range_we    = rule_we || (state_q == ST_CLEAR);
	assign range_waddr = (state_q == ST_CLEAR) ? clr_q :
		{RULE_AW'(rule_index), SLOT_W'(slot_index)};
	assign range_wdata = (state_q == ST_CLEAR) ? '0 :
		{slot_enable, slot_high, slot_low};
	assign range_raddr = {rule_q, slot_q};

	assign hit = rd_valid_s1 && range_rdata[RANGE_ENTRY_W-1]
		&& (rule_rdata[ACTION_W] || (rule_rdata[ACTION_W-1:0] == qact_q))
		&& (qopt_q >= range_rdata[BOUND_W-1:0])
		&& (qopt_q <= range_rdata[2*BOUND_W-1:BOUND_W]);

	assign done          = done_q;
	assign authorized    = auth_q;
	assign no_rules      = none_q;
	assign load_rejected = rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rule_q      <= '0;
			slot_q      <= '0;
			last_rule_q <= '0;
			issuing_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			done_q      <= 1'b0;
			auth_q      <= 1'b0;
			none_q      <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= issuing_q;
			rd_last_s1  <= issuing_q && issue_last;

			if (issuing_q) begin
				if (slot_q == SLOT_LAST) begin
					slot_q <= '0;
					rule_q <= rule_q + 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
				if (issue_last) begin
					issuing_q <= 1'b0;
				end
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (operation == OP_LOAD) begin
							done_q <= 1'b1;
							auth_q <= 1'b0;
							none_q <= 1'b0;
							rej_q  <= bad_bounds;
						end else if (cfg.allow_all) begin
							done_q <= 1'b1;
							auth_q <= 1'b1;
							none_q <= 1'b0;
							rej_q  <= 1'b0;
						end else if (cfg.rule_count == '0) begin
							done_q <= 1'b1;
							auth_q <= 1'b0;
							none_q <= 1'b1;
							rej_q  <= 1'b0;
						end else begin
							state_q     <= ST_SCAN;
							rule_q      <= '0;
							slot_q      <= '0;
							last_rule_q <= RULE_AW'(n_rules - 9'd1);
							issuing_q   <= 1'b1;
							rd_valid_s1 <= 1'b0;
							qact_q      <= query_action;
							qopt_q      <= query_option;
						end
					end
				end
				ST_SCAN: begin
					if (hit || (rd_valid_s1 && rd_last_s1)) begin
						// early exit on first match; drop the read still in flight
						done_q      <= 1'b1;
						auth_q      <= hit;
						none_q      <= 1'b0;
						rej_q       <= 1'b0;
						state_q     <= ST_IDLE;
						issuing_q   <= 1'b0;
						rd_valid_s1 <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/action_option_range_acl.sv]
// Action/option range ACL matcher.
//
// Command port: an item is taken at a clock edge with start high and busy
// low. Loads write one rule's action fields and one range slot unless
// slot_low > slot_high; checks ask whether an (action, option) pair is
// permitted by the rule table. Every item gives one result word: done is
// high for exactly one cycle with authorized, no_rules and load_rejected
// valid; the receiver cannot stall. A load, or a check with allow_all set
// or a zero rule count, gives its result in the cycle after acceptance,
// and a new item may be taken then. Other checks scan one range slot per
// cycle through the range memory, over every slot of the first n rules, n
// being the clamped rule count, and stop on the first matching slot; busy
// holds until the result cycle. The scan rate is set by the single read
// port of the range memory.
// After reset the range memory is cleared, one entry a cycle, all
// MAX_RULES * 2**ceil(log2(MAX_RANGES)) entries (128 by default) with busy
// high; configuration writes through the APB port are taken throughout.
// Depends on aora_pkg, aora_regs, aora_ctrl and aora_ram.
module action_option_range_acl import aora_pkg::*; #(
	parameter int MAX_RULES  = 16,
	parameter int MAX_RANGES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic [3:0]          rule_index,
	input  logic [2:0]          slot_index,
	input  logic [ACTION_W-1:0] rule_action_id,
	input  logic                rule_any_action,
	input  logic [BOUND_W-1:0]  slot_low,
	input  logic [BOUND_W-1:0]  slot_high,
	input  logic                slot_enable,
	input  logic [ACTION_W-1:0] query_action,
	input  logic [BOUND_W-1:0]  query_option,
	output logic                done,
	output logic                authorized,
	output logic                no_rules,
	output logic                load_rejected
);

	localparam int RULE_AW     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int SLOT_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int RANGE_AW    = RULE_AW + SLOT_W;
	localparam int RANGE_DEPTH = MAX_RULES * (1 << SLOT_W);

	cfg_t                     cfg;
	logic                     rule_we;
	logic [RULE_AW-1:0]       rule_waddr;
	logic [RULE_ENTRY_W-1:0]  rule_wdata;
	logic [RULE_AW-1:0]       rule_raddr;
	logic [RULE_ENTRY_W-1:0]  rule_rdata;
	logic                     range_we;
	logic [RANGE_AW-1:0]      range_waddr;
	logic [RANGE_ENTRY_W-1:0] range_wdata;
	logic [RANGE_AW-1:0]      range_raddr;
	logic [RANGE_ENTRY_W-1:0] range_rdata;

	aora_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// rule memory needs no clearing: it is only looked at through a valid slot,
	// and any valid slot was written together with its rule's action fields
	aora_ram #(
		.WIDTH  (RULE_ENTRY_W),
		.DEPTH  (MAX_RULES),
		.ADDR_W (RULE_AW)
	) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);

	aora_ram #(
		.WIDTH  (RANGE_ENTRY_W),
		.DEPTH  (RANGE_DEPTH),
		.ADDR_W (RANGE_AW)
	) u_range_ram (
		.clk   (clk),
		.we    (range_we),
		.waddr (range_waddr),
		.wdata (range_wdata),
		.raddr (range_raddr),
		.rdata (range_rdata)
	);

	aora_ctrl #(
		.MAX_RULES  (MAX_RULES),
		.MAX_RANGES (MAX_RANGES),
		.RULE_AW    (RULE_AW),
		.SLOT_W     (SLOT_W),
		.RANGE_AW   (RANGE_AW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.rule_index      (rule_index),
		.slot_index      (slot_index),
		.rule_action_id  (rule_action_id),
		.rule_any_action (rule_any_action),
		.slot_low        (slot_low),
		.slot_high       (slot_high),
		.slot_enable     (slot_enable),
		.query_action    (query_action),
		.query_option    (query_option),
		.done            (done),
		.authorized      (authorized),
		.no_rules        (no_rules),
		.load_rejected   (load_rejected),
		.rule_we         (rule_we),
		.rule_waddr      (rule_waddr),
		.rule_wdata      (rule_wdata),
		.rule_raddr      (rule_raddr),
		.rule_rdata      (rule_rdata),
		.range_we        (range_we),
		.range_waddr     (range_waddr),
		.range_wdata     (range_wdata),
		.range_raddr     (range_raddr),
		.range_rdata     (range_rdata)
	);

	// a load answers in the next cycle, never authorized
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_LOAD)
		|=> done && !authorized && !no_rules)
		else $error("load result missing or wrong");

	// allow-all checks answer without a scan, authorized
	a_allow_all: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_CHECK) && cfg.allow_all
		|=> done && authorized && !no_rules && !load_rejected)
		else $error("allow-all check not authorized");

	// a result word never overlaps an item still in work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// no range write while a check scan is running
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy) && !$past(range_we) |-> !range_we)
		else $error("range memory written during scan");

endmodule

[sim/tb_action_option_range_acl.sv]
`timescale 1ns / 1ps
// Self-checking bench for action_option_range_acl: rule loads and action/option checks are
// scored against a local copy of the rule table and registers on every done strobe.
// Depends on aora_pkg and the action_option_range_acl RTL; needs no other files.
module tb_action_option_range_acl import aora_pkg::*; ();

	localparam int RULES = 16;
	localparam int SLOTS = 8;
	localparam int GAP_MAX = 17;

	typedef struct {
		bit                op;
		bit [3:0]          rule;
		bit [2:0]          slot;
		bit [ACTION_W-1:0] act;
		bit                any;
		bit [BOUND_W-1:0]  lo;
		bit [BOUND_W-1:0]  hi;
		bit                en;
		bit [ACTION_W-1:0] q_act;
		bit [BOUND_W-1:0]  q_opt;
		int                gap;
	} acl_cmd_t;

	typedef struct {
		bit authorized;
		bit no_rules;
		bit rejected;
	} verdict_t;

	// accepted ranges, kept only to steer checks onto interesting options
	typedef struct {
		bit [ACTION_W-1:0] act;
		bit                any;
		bit [BOUND_W-1:0]  lo;
		bit [BOUND_W-1:0]  hi;
	} span_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                start = 1'b0;
	logic                busy;
	logic                operation = 1'b0;
	logic [3:0]          rule_index = '0;
	logic [2:0]          slot_index = '0;
	logic [ACTION_W-1:0] rule_action_id = '0;
	logic                rule_any_action = 1'b0;
	logic [BOUND_W-1:0]  slot_low = '0;
	logic [BOUND_W-1:0]  slot_high = '0;
	logic                slot_enable = 1'b0;
	logic [ACTION_W-1:0] query_action = '0;
	logic [BOUND_W-1:0]  query_option = '0;
	logic                done;
	logic                authorized;
	logic                no_rules;
	logic                load_rejected;

	action_option_range_acl dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.operation(operation), .rule_index(rule_index), .slot_index(slot_index),
		.rule_action_id(rule_action_id), .rule_any_action(rule_any_action),
		.slot_low(slot_low), .slot_high(slot_high), .slot_enable(slot_enable),
		.query_action(query_action), .query_option(query_option),
		.done(done), .authorized(authorized), .no_rules(no_rules),
		.load_rejected(load_rejected)
	);

	// shadow rule table and registers
	bit [ACTION_W-1:0] tbl_action [RULES];
	bit                tbl_any    [RULES];
	bit [BOUND_W-1:0]  tbl_lo     [RULES*SLOTS];
	bit [BOUND_W-1:0]  tbl_hi     [RULES*SLOTS];
	bit                tbl_valid  [RULES*SLOTS];
	bit                cfg_allow = 1'b0;
	bit [COUNT_W-1:0]  cfg_count = '0;

	acl_cmd_t pending[$];
	verdict_t verdict_q[$];
	span_t    spans[$];
	acl_cmd_t cur_cmd;
	bit       presenting = 1'b0;
	int       idle_cnt = 0;
	int       gap_top = GAP_MAX;
	int       err_cnt = 0;
	int       n_loads = 0, n_rej = 0, n_checks = 0, n_auth = 0, n_none = 0;

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, int got, int want);
		err_cnt++;
		$display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// applies one accepted word to the shadow table and returns its result
	function automatic verdict_t apply_item(acl_cmd_t c);
		verdict_t v;
		int k;
		int n;
		v = '{default: 1'b0};
		if (c.op == OP_LOAD) begin
			if (c.lo > c.hi) begin
				v.rejected = 1'b1;
			end else begin
				k = int'(c.rule) * SLOTS + int'(c.slot);
				tbl_action[c.rule] = c.act;
				tbl_any[c.rule] = c.any;
				tbl_lo[k] = c.lo;
				tbl_hi[k] = c.hi;
				tbl_valid[k] = c.en;
			end
		end else if (cfg_allow) begin
			v.authorized = 1'b1;
		end else if (cfg_count == 0) begin
			v.no_rules = 1'b1;
		end else begin
			n = (cfg_count > RULES) ? RULES : int'(cfg_count);
			for (int r = 0; r < n; r++) begin
				if (tbl_any[r] || tbl_action[r] == c.q_act) begin
					for (int s = 0; s < SLOTS; s++) begin
						k = r * SLOTS + s;
						if (tbl_valid[k] && c.q_opt >= tbl_lo[k] && c.q_opt <= tbl_hi[k])
							v.authorized = 1'b1;
					end
				end
			end
		end
		return v;
	endfunction

	function automatic void push_load(bit [3:0] r, bit [2:0] s, bit [ACTION_W-1:0] act,
			bit any, bit [BOUND_W-1:0] lo, bit [BOUND_W-1:0] hi, bit en);
		acl_cmd_t c;
		c.op = OP_LOAD;
		c.rule = r;
		c.slot = s;
		c.act = act;
		c.any = any;
		c.lo = lo;
		c.hi = hi;
		c.en = en;
		c.q_act = $urandom;
		c.q_opt = $urandom;
		c.gap = $urandom_range(0, gap_top);
		pending.push_back(c);
		if (lo <= hi) begin
			spans.push_back('{act, any, lo, hi});
			if (spans.size() > 32)
				void'(spans.pop_front());
		end
	endfunction

	function automatic void push_check(bit [ACTION_W-1:0] act, bit [BOUND_W-1:0] opt);
		acl_cmd_t c;
		c.op = OP_CHECK;
		c.rule = $urandom;
		c.slot = $urandom;
		c.act = $urandom;
		c.any = $urandom;
		c.lo = $urandom;
		c.hi = $urandom;
		c.en = $urandom;
		c.q_act = act;
		c.q_opt = opt;
		c.gap = $urandom_range(0, gap_top);
		pending.push_back(c);
	endfunction

	// mostly well-formed loads from a small action set, and checks aimed at range edges
	function automatic void random_batch(int n);
		bit [ACTION_W-1:0] pool [4];
		bit [BOUND_W-1:0]  lo;
		bit [BOUND_W-1:0]  opt;
		span_t sp;
		int kind;
		int top;
		for (int i = 0; i < 4; i++)
			pool[i] = $urandom;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				lo = $urandom;
				top = int'(lo) + $urandom_range(0, 400);
				push_load($urandom, $urandom, pool[$urandom_range(0, 3)],
					$urandom_range(0, 7) == 0, lo,
					(top > 65535) ? 16'hFFFF : 16'(top), $urandom_range(0, 5) != 0);
			end else if (kind < 45) begin
				push_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
			end else if (kind < 50) begin
				lo = $urandom_range(1, 65535);
				push_load($urandom, $urandom, pool[$urandom_range(0, 3)], $urandom, lo,
					$urandom_range(0, int'(lo) - 1), $urandom);
			end else if (kind < 85 && spans.size() != 0) begin
				sp = spans[$urandom_range(0, spans.size() - 1)];
				case ($urandom_range(0, 4))
					0: opt = sp.lo - 16'd1;
					1: opt = sp.lo;
					2: opt = sp.hi;
					3: opt = sp.hi + 16'd1;
					default: opt = sp.lo + 16'($urandom_range(0, int'(sp.hi - sp.lo)));
				endcase
				push_check(sp.any ? 16'($urandom) : sp.act, opt);
			end else if (kind < 92) begin
				push_check(pool[$urandom_range(0, 3)], $urandom);
			end else begin
				push_check($urandom, $urandom);
			end
		end
	endfunction

	task automatic write_reg(logic [0:0] idx, bit [PDATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ALLOW_ALL:  cfg_allow = val[0];
			REG_RULE_COUNT: cfg_count = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || presenting || verdict_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_config(bit allow, int count);
		wait_idle();
		write_reg(REG_ALLOW_ALL, PDATA_W'(allow));
		write_reg(REG_RULE_COUNT, PDATA_W'(count));
	endtask

	// driver: one word on the command port at a time, idle gap drawn per word
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				verdict_q.push_back(apply_item(cur_cmd));
				if (cur_cmd.op == OP_LOAD)
					n_loads++;
				else
					n_checks++;
				presenting = 1'b0;
			end
			if (!presenting && pending.size() != 0) begin
				if (idle_cnt < pending[0].gap) begin
					idle_cnt++;
				end else begin
					cur_cmd = pending.pop_front();
					idle_cnt = 0;
					presenting = 1'b1;
					operation <= cur_cmd.op;
					rule_index <= cur_cmd.rule;
					slot_index <= cur_cmd.slot;
					rule_action_id <= cur_cmd.act;
					rule_any_action <= cur_cmd.any;
					slot_low <= cur_cmd.lo;
					slot_high <= cur_cmd.hi;
					slot_enable <= cur_cmd.en;
					query_action <= cur_cmd.q_act;
					query_option <= cur_cmd.q_opt;
				end
			end
			start <= presenting;
		end
	end

	// monitor: every done strobe is one result word
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done === 1'b1) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("result word with nothing pending, done", 1, 0);
			end else begin
				want = verdict_q.pop_front();
				if (authorized !== want.authorized)
					report_mismatch("authorized", authorized, want.authorized);
				if (no_rules !== want.no_rules)
					report_mismatch("no_rules", no_rules, want.no_rules);
				if (load_rejected !== want.rejected)
					report_mismatch("load_rejected", load_rejected, want.rejected);
				n_auth += want.authorized;
				n_none += want.no_rules;
				n_rej += want.rejected;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// registers at reset: every check sees no rules
		push_check(16'h0000, 16'h0000);
		push_load(4'd0, 3'd0, 16'h1234, 1'b0, 16'd100, 16'd200, 1'b1);
		push_load(4'd15, 3'd7, 16'hFFFF, 1'b0, 16'h0000, 16'hFFFF, 1'b1);
		push_load(4'd3, 3'd2, 16'h0000, 1'b1, 16'd500, 16'd500, 1'b1);
		push_load(4'd1, 3'd1, 16'h5555, 1'b0, 16'd201, 16'd200, 1'b1);
		// inverted bounds with the slot disabled: still rejected, rule 0 untouched
		push_load(4'd0, 3'd0, 16'hBEEF, 1'b1, 16'hFFFF, 16'h0000, 1'b0);
		push_load(4'd5, 3'd4, 16'h0042, 1'b0, 16'd10, 16'd20, 1'b1);
		push_load(4'd5, 3'd4, 16'h0042, 1'b0, 16'd10, 16'd20, 1'b0);
		push_load(4'd7, 3'd3, 16'h7777, 1'b0, 16'd1000, 16'd2000, 1'b1);
		push_check(16'hFFFF, 16'hFFFF);

		set_config(1'b0, RULES);
		push_check(16'h1234, 16'd100);
		push_check(16'h1234, 16'd200);
		push_check(16'h1234, 16'd99);
		push_check(16'h1234, 16'd201);
		push_check(16'hBEEF, 16'd150);
		push_check(16'hFFFF, 16'h0000);
		push_check(16'hFFFF, 16'hFFFF);
		push_check(16'hABCD, 16'd500);
		push_check(16'hABCD, 16'd501);
		push_check(16'h0042, 16'd15);
		push_check(16'h7777, 16'd1500);
		push_check(16'h7777, 16'd0);

		set_config(1'b1, RULES);
		push_check(16'h0001, 16'hFFFF);
		random_batch(30);

		set_config(1'b0, RULES);
		random_batch(100);
		set_config(1'b0, 5);
		random_batch(60);
		// count above the table size, back-to-back words
		set_config(1'b0, 17);
		gap_top = 0;
		random_batch(50);
		gap_top = GAP_MAX;
		set_config(1'b0, 31);
		random_batch(40);
		set_config(1'b0, 1);
		random_batch(40);
		set_config(1'b0, 0);
		random_batch(20);
		set_config(1'b1, 0);
		random_batch(20);

		wait_idle();
		repeat (140) @(posedge clk);
		$display("Covered %0d loads (%0d with inverted bounds) and %0d checks", n_loads, n_rej,
			n_checks);
		$display("(%0d permitted, %0d with an empty rule window) across the register settings",
			n_auth, n_none);
		if (err_cnt == 0 && verdict_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
